>>> hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority thread scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int THREADS         = 8;
    localparam int PERIODIC_EVENTS = 2;
    localparam int SEMAPHORES      = 4;
    localparam int TID_W           = $clog2(THREADS);
    localparam int SEM_W           = 2;
    localparam int PRIO_W          = 8;
    localparam logic [PRIO_W-1:0] NEVER_RUNS = 8'd255;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_SLICE  = 3'd1;
    localparam logic [2:0] MODE_SLEEP  = 3'd2;
    localparam logic [2:0] MODE_WAIT   = 3'd3;
    localparam logic [2:0] MODE_SIGNAL = 3'd4;
    localparam logic [2:0] MODE_INIT   = 3'd5;
    localparam logic [2:0] MODE_START  = 3'd6;

    localparam logic [1:0] REG_PRIO    = 2'd0;
    localparam logic [1:0] REG_ACTIVE  = 2'd1;
    localparam logic [1:0] REG_PERIOD0 = 2'd2;
    localparam logic [1:0] REG_PERIOD1 = 2'd3;

    // thread table entry: sleep count, blocked flag, semaphore blocked on
    localparam int THR_W = 32 + 1 + SEM_W;

    // packed from the top bit down: running_thread ends up in the low bits
    typedef struct packed {
        logic             signal_error;
        logic             none_ready;
        logic             caller_blocked;
        logic [1:0]       event_fire;
        logic [TID_W-1:0] running_thread;
    } result_t;

endpackage

>>> hw/rtl/priority_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// priority_thread_scheduler_core
// Eight-thread priority scheduler with periodic events and semaphores.
// ----------------------------------------------------------------------------
// Init and unused modes go straight to output, start runs a clearing pass,
// tick and time slice walk every thread, and sleep, wait and signal update the
// caller or semaphore first and may then walk. One item at a time; the thread
// table RAM port sets the walk. Reset: clears control; a clearing pass then
// empties the thread and semaphore tables before the first beat is taken.
module priority_thread_scheduler_core
    import pts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] mode, [4:3] sem_index, [20:5] sem_value, [52:21] sleep_ticks
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] running_thread, [4:3] event_fire, [5] caller_blocked,
    // [6] none_ready, [7] signal_error
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SEM_RD, S_SEM_OP, S_TICK_RD, S_TICK_WR,
        S_SCAN_RD, S_SCAN_EV, S_SIG_RD, S_SIG_EV, S_SLP_RD, S_SLP_WR, S_OUT
    } state_t;

    state_t state_reg;
    logic [63:0] prio_reg;
    logic [1:0]  active_reg;
    logic [31:0] period_reg [PERIODIC_EVENTS];
    logic [31:0] cd_reg     [PERIODIC_EVENTS];
    logic [TID_W-1:0] cur_reg, best_reg, idx_reg;
    logic [PRIO_W-1:0] bestp_reg;
    logic found_reg;
    logic [TID_W:0] cnt_reg;
    logic [2:0] mode_reg;
    logic [1:0] sem_reg;
    logic [31:0] ticks_reg;
    result_t res_reg;
    result_t acc_res;

    // thread table
    logic thr_we;
    logic [TID_W-1:0] thr_waddr, thr_raddr;
    logic [THR_W-1:0] thr_wdata, thr_rdata;
    // semaphore table
    logic sem_we;
    logic [SEM_W-1:0] sem_waddr;
    logic [15:0] sem_wdata, sem_rdata;

    pts_ram #(.WIDTH(THR_W), .DEPTH(THREADS)) u_thr (
        .clk(clk), .we(thr_we), .waddr(thr_waddr), .wdata(thr_wdata),
        .raddr(thr_raddr), .rdata(thr_rdata));
    pts_ram #(.WIDTH(16), .DEPTH(SEMAPHORES)) u_sem (
        .clk(clk), .we(sem_we), .waddr(sem_waddr), .wdata(sem_wdata),
        .raddr(sem_reg), .rdata(sem_rdata));

    logic [31:0] rd_sleep;
    logic        rd_blk;
    logic [SEM_W-1:0] rd_on;
    logic [PRIO_W-1:0] rd_prio;
    logic [15:0] sem_dec, sem_inc;
    logic [TID_W-1:0] idx_inc;

    assign rd_sleep = thr_rdata[31:0];
    assign rd_blk   = thr_rdata[32];
    assign rd_on    = thr_rdata[33 +: SEM_W];
    assign rd_prio  = prio_reg[idx_reg*PRIO_W +: PRIO_W];
    assign sem_dec  = sem_rdata - 16'd1;
    assign sem_inc  = sem_rdata + 16'd1;
    assign idx_inc  = idx_reg + 1'b1;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = res_reg;

    // result fields known at accept time
    always_comb
    begin
        acc_res = '0;
        acc_res.running_thread = (s_axis_tdata[2:0] == MODE_START) ? '0 : cur_reg;
        if (s_axis_tdata[2:0] == MODE_TICK)
        begin
            for (int e = 0; e < PERIODIC_EVENTS; e++)
            begin
                if (e < active_reg && cd_reg[e] == 32'd1)
                begin
                    acc_res.event_fire[e] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        thr_we    = 1'b0;
        thr_waddr = idx_reg;
        thr_wdata = thr_rdata;
        thr_raddr = idx_reg;
        sem_we    = 1'b0;
        sem_waddr = sem_reg;
        sem_wdata = sem_dec;
        case (state_reg)
            S_CLEAR:
            begin
                thr_we    = 1'b1;
                thr_waddr = cnt_reg[TID_W-1:0];
                thr_wdata = '0;
                // start keeps the semaphore counts
                sem_we    = (mode_reg != MODE_START);
                sem_waddr = cnt_reg[SEM_W-1:0];
                sem_wdata = '0;
            end
            S_IDLE:
            begin
                thr_raddr = idx_inc;
                if (s_axis_tvalid)
                begin
                    case (s_axis_tdata[2:0])
                        MODE_INIT:
                        begin
                            sem_we    = 1'b1;
                            sem_waddr = s_axis_tdata[4:3];
                            sem_wdata = s_axis_tdata[20:5];
                        end
                        default: ;
                    endcase
                end
            end
            S_SEM_RD: thr_raddr = cur_reg;
            S_SEM_OP:
            begin
                sem_we    = 1'b1;
                sem_wdata = (mode_reg == MODE_WAIT) ? sem_dec : sem_inc;
                if (mode_reg == MODE_WAIT && sem_dec[15])
                begin
                    thr_we    = 1'b1;
                    thr_waddr = cur_reg;
                    thr_wdata = {sem_reg, 1'b1, rd_sleep};
                end
            end
            S_SLP_RD: thr_raddr = cur_reg;
            S_SLP_WR:
            begin
                thr_we    = 1'b1;
                thr_waddr = cur_reg;
                thr_wdata = {rd_on, rd_blk, ticks_reg};
            end
            S_TICK_RD: thr_raddr = idx_reg;
            S_TICK_WR:
            begin
                thr_we    = 1'b1;
                thr_wdata = {rd_on, rd_blk, rd_sleep - (rd_sleep != 32'd0 ? 32'd1 : 32'd0)};
                thr_raddr = idx_inc;
            end
            S_SCAN_RD, S_SIG_RD: thr_raddr = idx_reg;
            S_SIG_EV:
            begin
                if (rd_blk && rd_on == sem_reg && !found_reg)
                begin
                    thr_we    = 1'b1;
                    thr_wdata = {{SEM_W{1'b0}}, 1'b0, rd_sleep};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            prio_reg   <= '0;
            active_reg <= '0;
            for (int e = 0; e < PERIODIC_EVENTS; e++)
            begin
                period_reg[e] <= 32'd1;
                cd_reg[e]     <= 32'd1;
            end
            cur_reg   <= '0;
            best_reg  <= '0;
            idx_reg   <= '0;
            bestp_reg <= NEVER_RUNS;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
            mode_reg  <= '0;
            sem_reg   <= '0;
            ticks_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_PRIO:    prio_reg      <= cfg_data;
                    REG_ACTIVE:  active_reg    <= cfg_data[1:0];
                    REG_PERIOD0: period_reg[0] <= cfg_data[31:0];
                    REG_PERIOD1: period_reg[1] <= cfg_data[31:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (TID_W+1)'(THREADS - 1))
                    begin
                        state_reg <= (mode_reg == MODE_START) ? S_OUT : S_IDLE;
                        idx_reg   <= cur_reg - 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        mode_reg  <= s_axis_tdata[2:0];
                        sem_reg   <= s_axis_tdata[4:3];
                        ticks_reg <= s_axis_tdata[52:21];
                        res_reg   <= acc_res;
                        bestp_reg <= NEVER_RUNS;
                        best_reg  <= cur_reg;
                        found_reg <= 1'b0;
                        cnt_reg   <= '0;
                        idx_reg   <= (s_axis_tdata[2:0] == MODE_TICK) ? '0 : cur_reg + 1'b1;
                        case (s_axis_tdata[2:0])
                            MODE_TICK:
                            begin
                                for (int e = 0; e < PERIODIC_EVENTS; e++)
                                begin
                                    if (e < active_reg)
                                    begin
                                        if (cd_reg[e] == 32'd1)
                                        begin
                                            cd_reg[e] <= period_reg[e];
                                        end
                                        else
                                        begin
                                            cd_reg[e] <= cd_reg[e] - 32'd1;
                                        end
                                    end
                                end
                                state_reg <= S_TICK_RD;
                            end
                            MODE_SLICE: state_reg <= S_SCAN_RD;
                            MODE_SLEEP: state_reg <= S_SLP_RD;
                            MODE_WAIT, MODE_SIGNAL: state_reg <= S_SEM_RD;
                            MODE_START:
                            begin
                                cur_reg <= '0;
                                for (int e = 0; e < PERIODIC_EVENTS; e++)
                                begin
                                    cd_reg[e] <= period_reg[e];
                                end
                                state_reg <= S_CLEAR;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_SLP_RD: state_reg <= S_SLP_WR;
                S_SLP_WR: state_reg <= S_SCAN_RD;
                S_SEM_RD: state_reg <= S_SEM_OP;
                S_SEM_OP:
                begin
                    if (mode_reg == MODE_WAIT)
                    begin
                        if (sem_dec[15])
                        begin
                            res_reg.caller_blocked <= 1'b1;
                            state_reg <= S_SCAN_RD;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else if (sem_inc[15] || sem_inc == 16'd0)
                    begin
                        state_reg <= S_SIG_RD;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_TICK_RD: state_reg <= S_TICK_WR;
                S_TICK_WR:
                begin
                    idx_reg <= idx_inc;
                    cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= (cnt_reg == (TID_W+1)'(THREADS - 1)) ? S_OUT : S_TICK_RD;
                end
                S_SCAN_RD, S_SIG_RD:
                    state_reg <= (state_reg == S_SCAN_RD) ? S_SCAN_EV : S_SIG_EV;
                S_SCAN_EV:
                begin
                    if (!rd_blk && rd_sleep == 32'd0 && rd_prio < bestp_reg)
                    begin
                        bestp_reg <= rd_prio;
                        best_reg  <= idx_reg;
                        found_reg <= 1'b1;
                    end
                    idx_reg <= idx_inc;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (TID_W+1)'(THREADS - 1))
                    begin
                        state_reg <= S_OUT;
                        if (!rd_blk && rd_sleep == 32'd0 && rd_prio < bestp_reg)
                        begin
                            cur_reg <= idx_reg;
                            res_reg.running_thread <= idx_reg;
                            res_reg.none_ready <= 1'b0;
                        end
                        else
                        begin
                            cur_reg <= best_reg;
                            res_reg.running_thread <= best_reg;
                            res_reg.none_ready <= !found_reg;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SIG_EV:
                begin
                    if (rd_blk && rd_on == sem_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg <= idx_inc;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (TID_W+1)'(THREADS - 1))
                    begin
                        res_reg.signal_error <= !(found_reg || (rd_blk && rd_on == sem_reg));
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SIG_RD;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                        idx_reg   <= cur_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> bench/priority_thread_scheduler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_thread_scheduler_core_tb
// Self-checking bench: a local scheduler predictor runs on every accepted
// input beat and each output beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module priority_thread_scheduler_core_tb;
    import pts_pkg::*;

    typedef struct packed {
        logic [31:0] sleep_ticks;
        logic [15:0] sem_value;
        logic [1:0]  sem_index;
        logic [2:0]  mode;
    } item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    priority_thread_scheduler_core uut (.*);

    always #2 clk = ~clk;

    // predictor state
    logic [63:0] prio_reg = '0;
    logic [1:0]  active_reg = '0;
    logic [31:0] period_reg [PERIODIC_EVENTS] = '{32'd1, 32'd1};
    logic [2:0]  cur_thr = '0;
    logic [31:0] sleep_left [THREADS] = '{default: '0};
    logic        blk [THREADS] = '{default: 1'b0};
    logic [1:0]  blk_sem [THREADS] = '{default: '0};
    logic [15:0] sem_cnt [SEMAPHORES] = '{default: '0};
    logic [31:0] countdown [PERIODIC_EVENTS] = '{32'd1, 32'd1};

    item_t   pending_items [$];
    result_t expected_results [$];
    int      errors = 0;
    bit      hold_feed = 1'b0;

    function automatic logic pick_next();
        logic [2:0] best;
        logic [8:0] bestp;
        logic       found;
        logic [2:0] t;
        logic [7:0] p;
        best = cur_thr;
        bestp = {1'b0, NEVER_RUNS};
        found = 1'b0;
        for (int k = 1; k <= THREADS; k++)
        begin
            t = cur_thr + k[2:0];
            p = prio_reg[8*t +: 8];
            if (!blk[t] && sleep_left[t] == 0 && {1'b0, p} < bestp)
            begin
                bestp = {1'b0, p};
                best = t;
                found = 1'b1;
            end
        end
        cur_thr = best;
        return !found;
    endfunction

    function automatic result_t schedule_item(item_t it);
        result_t r;
        int n;
        logic woke;
        logic [2:0] t;
        r = '0;
        case (it.mode)
            MODE_TICK:
            begin
                n = (active_reg > PERIODIC_EVENTS) ? PERIODIC_EVENTS : active_reg;
                for (int e = 0; e < n; e++)
                begin
                    countdown[e] = countdown[e] - 32'd1;
                    if (countdown[e] == 0)
                    begin
                        r.event_fire[e] = 1'b1;
                        countdown[e] = period_reg[e];
                    end
                end
                for (int i = 0; i < THREADS; i++)
                    if (sleep_left[i] != 0)
                        sleep_left[i] = sleep_left[i] - 32'd1;
            end
            MODE_SLICE: r.none_ready = pick_next();
            MODE_SLEEP:
            begin
                sleep_left[cur_thr] = it.sleep_ticks;
                r.none_ready = pick_next();
            end
            MODE_WAIT:
            begin
                sem_cnt[it.sem_index] = sem_cnt[it.sem_index] - 16'd1;
                if ($signed(sem_cnt[it.sem_index]) < 0)
                begin
                    blk[cur_thr] = 1'b1;
                    blk_sem[cur_thr] = it.sem_index;
                    r.caller_blocked = 1'b1;
                    r.none_ready = pick_next();
                end
            end
            MODE_SIGNAL:
            begin
                sem_cnt[it.sem_index] = sem_cnt[it.sem_index] + 16'd1;
                if ($signed(sem_cnt[it.sem_index]) <= 0)
                begin
                    woke = 1'b0;
                    for (int k = 1; k <= THREADS; k++)
                    begin
                        t = cur_thr + k[2:0];
                        if (!woke && blk[t] && blk_sem[t] == it.sem_index)
                        begin
                            blk[t] = 1'b0;
                            blk_sem[t] = '0;
                            woke = 1'b1;
                        end
                    end
                    r.signal_error = !woke;
                end
            end
            MODE_INIT: sem_cnt[it.sem_index] = it.sem_value;
            MODE_START:
            begin
                cur_thr = '0;
                for (int i = 0; i < THREADS; i++)
                begin
                    sleep_left[i] = '0;
                    blk[i] = 1'b0;
                    blk_sem[i] = '0;
                end
                for (int e = 0; e < PERIODIC_EVENTS; e++)
                    countdown[e] = period_reg[e];
            end
            default: ;
        endcase
        r.running_thread = cur_thr;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // input driver
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(schedule_item(item_t'(s_axis_tdata[52:0])));
                void'(pending_items.pop_front());
                in_gap = gap_len();
            end
            if ((!s_axis_tvalid || s_axis_tready) || !s_axis_tvalid)
            begin
                if (in_gap > 0 && !(s_axis_tvalid && !s_axis_tready))
                begin
                    in_gap = in_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0 && !hold_feed)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b0, pending_items[0]};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output monitor
    int out_gap = 0;
    always @(posedge clk)
    begin
        result_t got, exp_r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r)
                    begin
                        $display({"%0t: mismatch expected thr=%0d fire=%b blk=%b none=%b",
                            " err=%b actual thr=%0d fire=%b blk=%b none=%b err=%b"},
                            $time, exp_r.running_thread, exp_r.event_fire,
                            exp_r.caller_blocked, exp_r.none_ready, exp_r.signal_error,
                            got.running_thread, got.event_fire, got.caller_blocked,
                            got.none_ready, got.signal_error);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                out_gap = gap_len();
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PRIO:    prio_reg = val;
            REG_ACTIVE:  active_reg = val[1:0];
            REG_PERIOD0: period_reg[0] = val[31:0];
            default:     period_reg[1] = val[31:0];
        endcase
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (2 * THREADS + 10) @(posedge clk);
    endtask

    function automatic item_t mk(logic [2:0] m, logic [1:0] s, logic [15:0] v, logic [31:0] t);
        item_t it;
        it.mode = m;
        it.sem_index = s;
        it.sem_value = v;
        it.sleep_ticks = t;
        return it;
    endfunction

    function automatic item_t rand_item();
        int r;
        logic [31:0] t;
        r = $urandom_range(0, 99);
        t = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 6);
        if (r < 35) return mk(MODE_TICK, 0, 0, 0);
        if (r < 45) return mk(MODE_SLICE, 2'($urandom), 16'($urandom), $urandom);
        if (r < 55) return mk(MODE_SLEEP, 2'($urandom), 16'($urandom), t);
        if (r < 70) return mk(MODE_WAIT, 2'($urandom), 16'($urandom), $urandom);
        if (r < 85) return mk(MODE_SIGNAL, 2'($urandom), 16'($urandom), $urandom);
        if (r < 92)
            return mk(MODE_INIT, 2'($urandom), ($urandom_range(0, 9) == 0) ? 16'($urandom)
                : 16'($urandom_range(0, 4) - 2), $urandom);
        if (r < 97) return mk(MODE_START, 2'($urandom), 16'($urandom), $urandom);
        return mk(3'd7, 2'($urandom), 16'($urandom), $urandom);
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // directed
        pending_items.push_back(mk(MODE_TICK, 0, 0, 0));
        pending_items.push_back(mk(MODE_SLICE, 0, 0, 0));
        pending_items.push_back(mk(MODE_INIT, 0, 16'h7fff, 0));
        pending_items.push_back(mk(MODE_SIGNAL, 0, 0, 0));
        pending_items.push_back(mk(MODE_INIT, 1, 16'h8000, 32'hffffffff));
        pending_items.push_back(mk(MODE_WAIT, 1, 16'hffff, 0));
        pending_items.push_back(mk(MODE_INIT, 2, 0, 0));
        pending_items.push_back(mk(MODE_WAIT, 2, 0, 0));
        pending_items.push_back(mk(MODE_SIGNAL, 2, 0, 0));
        pending_items.push_back(mk(MODE_SIGNAL, 3, 0, 0));
        pending_items.push_back(mk(MODE_SIGNAL, 3, 0, 0));
        pending_items.push_back(mk(MODE_SLEEP, 0, 0, 32'hffffffff));
        pending_items.push_back(mk(MODE_SLEEP, 0, 0, 0));
        pending_items.push_back(mk(MODE_SLEEP, 0, 0, 2));
        pending_items.push_back(mk(MODE_TICK, 0, 0, 0));
        pending_items.push_back(mk(3'd7, 3, 16'hffff, 32'hffffffff));
        pending_items.push_back(mk(MODE_START, 0, 0, 0));
        drain();
        write_reg(REG_PRIO, 64'h0302_0100_FF04_0506);
        write_reg(REG_ACTIVE, 2'd2);
        write_reg(REG_PERIOD0, 64'd1);
        write_reg(REG_PERIOD1, 64'd3);
        for (int ph = 0; ph < 10; ph++)
        begin
            pending_items.push_back(mk(MODE_START, 0, 0, 0));
            for (int i = 0; i < 190; i++)
                pending_items.push_back(rand_item());
            if (ph == 4)
            begin
                wait (pending_items.size() < 100);
                hold_feed = 1'b1;
                wait (expected_results.size() == 0 && !s_axis_tvalid);
                hold_feed = 1'b0;
            end
            drain();
            case (ph)
                0: write_reg(REG_PRIO, 64'hFFFF_FFFF_FFFF_FFFF);
                1: write_reg(REG_PRIO, 64'h0);
                2: write_reg(REG_ACTIVE, 2'd3);
                3: write_reg(REG_PERIOD0, 64'd0);
                4: write_reg(REG_PERIOD1, 64'hFFFF_FFFF);
                5: write_reg(REG_ACTIVE, 2'd1);
                6: write_reg(REG_PRIO, {$urandom, $urandom} | 64'hFF);
                7: write_reg(REG_ACTIVE, 2'd0);
                default:
                begin
                    write_reg(REG_PRIO, {$urandom, $urandom});
                    write_reg(REG_ACTIVE, 2'd2);
                    write_reg(REG_PERIOD0, 64'd2);
                    write_reg(REG_PERIOD1, 64'd5);
                end
            endcase
        end
        if (errors == 0)
            $display("PASS priority_thread_scheduler_core");
        else
            $display("FAIL priority_thread_scheduler_core");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL priority_thread_scheduler_core");
        $finish;
    end

endmodule
